### design/rjb_pkg.sv
package rjb_pkg;

    localparam int SLOTS = 64;
    localparam int SW = $clog2(SLOTS);
    localparam int WIN = SLOTS / 4;
    localparam int HALF = SLOTS / 2;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int LIMW = $clog2(WIN + 1);
    // slot entry: seq 16, media 32, arrival 32, length 16, marker 1
    localparam int EW = 97;

    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_GET    = 2'd1,
        OP_REPORT = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_STORED    = 4'd0,
        ST_DUP       = 4'd1,
        ST_LATE      = 4'd2,
        ST_AHEAD     = 4'd3,
        ST_TOO_LARGE = 4'd4,
        ST_NOT_READY = 4'd5,
        ST_LOST      = 4'd6,
        ST_DELIVERED = 4'd7,
        ST_TOO_SMALL = 4'd8,
        ST_MISSING   = 4'd9,
        ST_NONE      = 4'd10
    } t_status;

    typedef enum logic [1:0] {
        CFG_TARGET  = 2'd0,
        CFG_MIN     = 2'd1,
        CFG_MAX     = 2'd2,
        CFG_PAYLOAD = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_SCAN,
        S_EMIT,
        S_WAIT
    } t_state;

    typedef struct packed {
        logic [3:0]  status;
        logic [15:0] seq_out;
        logic [5:0]  slot_index;
        logic [15:0] length_out;
        logic [31:0] media_time_out;
        logic        marker_out;
        logic [6:0]  occupancy;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] seq_number;
        logic [31:0] media_time;
        logic        frame_marker;
        logic [15:0] length_in;
        logic [31:0] now_time;
        logic [15:0] room;
        logic [4:0]  report_limit;
    } t_request;

endpackage

### design/rjb_if.sv
interface rjb_if #(
    parameter int W = 1
);
    logic         valid;
    logic         ready;
    logic [W-1:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### design/rjb_ram.sv
module rjb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### design/rtp_jitter_reorder_buffer.sv
// RTP jitter reorder buffer. Requests enter on the request channel (a t_request
// payload) and produce one or more t_result items on the result channel, the
// final one flagged by last. Put stores a packet descriptor in slot seq mod 64;
// get releases the head packet once its age reaches the clamped playout
// delay and its length fits in room, or skips a missing head when a later
// packet sits within a quarter window; report lists up to 16 gaps in the
// head window. Descriptors live in one single-port-read RAM, valid bits in
// flip-flops. A put or get reads the RAM in the read state, then executes,
// writes back and registers its result in the execute state; the wait
// state holds the result until it is taken and then returns to idle. A
// report first scans every position of the head window, then walks the
// window positions up to the last filled slot (cut short at the limit),
// emitting a result for each gap, or a single closing result if none was
// found. A stalled result holds the walk. The result register holds a
// finished result until taken, and a new request is accepted once the last
// result of the previous one has been taken.
module rtp_jitter_reorder_buffer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    rjb_if.sink         req,
    rjb_if.source       res
);
    import rjb_pkg::*;

    logic [15:0] r_target, r_min, r_max, r_payload;
    t_state      r_state, n_state;
    t_request    r_req;
    logic        r_started;
    logic [15:0] r_head;
    logic [SLOTS-1:0] r_valid;
    logic [CW-1:0] r_count;
    t_result     r_res, n_res;
    logic        r_res_v, n_res_v;
    // report scan
    logic [LIMW-1:0] r_i;
    logic [LIMW-1:0] r_lastv;
    logic            r_anyv;
    logic [LIMW-1:0] r_pos;
    logic [LIMW-1:0] r_n;
    logic [LIMW-1:0] r_limit;

    logic [EW-1:0] ram_rdata, ram_wdata;
    logic          ram_we;
    logic [SW-1:0] ram_raddr, ram_waddr;

    rjb_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= 16'd50;
            r_min     <= 16'd10;
            r_max     <= 16'd500;
            r_payload <= 16'd1500;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TARGET:  r_target  <= i_cfg_data;
                CFG_MIN:     r_min     <= i_cfg_data;
                CFG_MAX:     r_max     <= i_cfg_data;
                CFG_PAYLOAD: r_payload <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // put decode; the first put takes its own seq as head
    logic [15:0] put_head, dlt, eff, eff0;
    logic [SW-1:0] put_slot, head_slot;
    logic late, ahead, dup;
    logic [15:0] e_seq, e_len;
    logic [31:0] e_mt, e_arr;
    logic        e_mk;
    logic later;
    logic put_ok, head_young, get_lost, get_dlv;

    assign {e_seq, e_mt, e_arr, e_len, e_mk} = ram_rdata;
    assign put_head = r_started ? r_head : r_req.seq_number;
    assign dlt = r_req.seq_number - put_head;
    assign put_slot = r_req.seq_number[SW-1:0];
    assign head_slot = r_head[SW-1:0];
    assign late = dlt[15] && (dlt < 16'(65536 - HALF));
    assign ahead = !dlt[15] && (dlt >= 16'(HALF));
    assign dup = r_valid[put_slot] && (e_seq == r_req.seq_number);
    assign eff0 = (r_target < r_min) ? r_min : r_target;
    assign eff = (eff0 > r_max) ? r_max : eff0;

    always_comb begin
        later = 1'b0;
        for (int k = 1; k < WIN; k++) begin
            if (r_valid[SW'(r_head + 16'(k))]) later = 1'b1;
        end
    end

    assign put_ok = !late && !ahead && !dup && (r_req.length_in <= r_payload);
    assign head_young = (r_req.now_time - e_arr) < {16'd0, eff};
    assign get_lost = r_started && !r_valid[head_slot] && later;
    assign get_dlv = r_started && r_valid[head_slot] && !head_young
                     && (e_len <= r_req.room);

    logic [15:0] scan_seq;
    assign scan_seq = r_head + 16'(r_i);
    assign ram_raddr = (r_req.operation == OP_PUT) ? put_slot : head_slot;

    // gap walk: a window position below the last filled one with an empty slot
    logic [15:0] emit_seq;
    logic        emit_end, emit_gap, more_gaps;
    assign emit_seq = r_head + 16'(r_pos);
    assign emit_end = !r_anyv || r_pos >= r_lastv || r_n >= r_limit;
    assign emit_gap = !r_valid[emit_seq[SW-1:0]];

    // any gap left past the current position decides last
    always_comb begin
        more_gaps = 1'b0;
        for (int k = 0; k < WIN; k++) begin
            if (LIMW'(k) > r_pos && LIMW'(k) < r_lastv
                    && !r_valid[SW'(r_head + 16'(k))])
                more_gaps = 1'b1;
        end
    end

    t_result rz;
    always_comb begin
        rz = '0;
        rz.occupancy = 7'(r_count);
    end

    assign req.ready = (r_state == S_IDLE);
    assign res.valid = r_res_v;
    assign res.payload = r_res;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (req.valid) n_state = S_READ;
            S_READ: n_state = S_EXEC;
            S_EXEC: n_state = (r_req.operation == OP_REPORT && r_started) ? S_SCAN : S_WAIT;
            S_SCAN: if (r_i == LIMW'(WIN - 1)) n_state = S_EMIT;
            S_EMIT: if (!r_res_v || res.ready) begin
                if (emit_end) n_state = S_WAIT;
            end
            S_WAIT: if (!r_res_v || res.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ram_we = 1'b0;
        ram_waddr = put_slot;
        ram_wdata = {r_req.seq_number, r_req.media_time, r_req.now_time,
                     r_req.length_in, r_req.frame_marker};
        if (r_state == S_EXEC && r_req.operation == OP_PUT && put_ok)
            ram_we = 1'b1;
    end

    // result register next value
    always_comb begin
        n_res = r_res;
        n_res_v = r_res_v;
        if (r_res_v && res.ready) n_res_v = 1'b0;
        if (r_state == S_EXEC) begin
            n_res = rz;
            n_res.last = 1'b1;
            n_res.status = ST_NONE;
            case (r_req.operation)
                OP_PUT: begin
                    n_res.seq_out = r_req.seq_number;
                    n_res.slot_index = 6'(put_slot);
                    if (late) n_res.status = ST_LATE;
                    else if (ahead) n_res.status = ST_AHEAD;
                    else if (dup) n_res.status = ST_DUP;
                    else if (r_req.length_in > r_payload) n_res.status = ST_TOO_LARGE;
                    else begin
                        n_res.status = ST_STORED;
                        if (!r_valid[put_slot]) n_res.occupancy = 7'(r_count + 1'b1);
                    end
                end
                OP_GET: begin
                    if (!r_started) n_res.status = ST_NOT_READY;
                    else begin
                        n_res.seq_out = r_head;
                        n_res.slot_index = 6'(head_slot);
                        if (!r_valid[head_slot]) begin
                            n_res.status = later ? ST_LOST : ST_NOT_READY;
                        end else if (head_young)
                            n_res.status = ST_NOT_READY;
                        else if (e_len > r_req.room) n_res.status = ST_TOO_SMALL;
                        else begin
                            n_res.status = ST_DELIVERED;
                            n_res.seq_out = e_seq;
                            n_res.length_out = e_len;
                            n_res.media_time_out = e_mt;
                            n_res.marker_out = e_mk;
                            n_res.occupancy = 7'(r_count - 1'b1);
                        end
                    end
                end
                default: ;
            endcase
            if (r_req.operation != OP_REPORT || !r_started) n_res_v = 1'b1;
        end
        if (r_state == S_EMIT && (!r_res_v || res.ready)) begin
            if (emit_end) begin
                if (r_n == '0) begin
                    n_res = rz;
                    n_res.status = ST_NONE;
                    n_res.last = 1'b1;
                    n_res_v = 1'b1;
                end
            end else if (emit_gap) begin
                n_res = rz;
                n_res.status = ST_MISSING;
                n_res.seq_out = emit_seq;
                n_res.slot_index = 6'(emit_seq[SW-1:0]);
                n_res.last = ((r_n + LIMW'(1)) == r_limit) || !more_gaps;
                n_res_v = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_started <= 1'b0;
            r_head    <= '0;
            r_valid   <= '0;
            r_count   <= '0;
            r_res_v   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
            r_res_v <= n_res_v;
            if (r_state == S_IDLE && req.valid) r_req <= req.payload;
            if (r_state == S_EXEC) begin
                r_i <= '0;
                r_pos <= '0;
                r_n <= '0;
                r_anyv <= 1'b0;
                r_lastv <= '0;
                r_limit <= (r_req.report_limit > 5'(WIN)) ? LIMW'(WIN)
                         : LIMW'(r_req.report_limit);
                case (r_req.operation)
                    OP_PUT: begin
                        r_started <= 1'b1;
                        r_head <= put_head;
                        if (put_ok) begin
                            r_valid[put_slot] <= 1'b1;
                            if (!r_valid[put_slot]) r_count <= r_count + 1'b1;
                        end
                    end
                    OP_GET: begin
                        if (get_lost) r_head <= r_head + 16'd1;
                        else if (get_dlv) begin
                            r_valid[head_slot] <= 1'b0;
                            r_count <= r_count - 1'b1;
                            r_head <= r_head + 16'd1;
                        end
                    end
                    default: ;
                endcase
            end
            if (r_state == S_SCAN) begin
                if (r_valid[scan_seq[SW-1:0]]) begin
                    r_anyv <= 1'b1;
                    r_lastv <= r_i;
                end
                r_i <= r_i + 1'b1;
            end
            if (r_state == S_EMIT && (!r_res_v || res.ready) && !emit_end) begin
                r_pos <= r_pos + 1'b1;
                if (emit_gap) r_n <= r_n + 1'b1;
            end
        end
    end

endmodule
